[hdl/i2c_master_adc_dac_transfer_defines.svh]
// Assertion macros shared by the bus master RTL.
// No dependencies; included by the modules that carry checks.
`ifndef I2C_MASTER_ADC_DAC_TRANSFER_DEFINES_SVH
`define I2C_MASTER_ADC_DAC_TRANSFER_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define I2CAD_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked outside reset.
`define I2CAD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[hdl/i2cad_pkg.sv]
// Shared types and constants of the bus master.
// No dependencies.
`default_nettype none
package i2cad_pkg;

	localparam int QUEUE_DEPTH_DEF = 2;

	localparam logic [6:0] DEV_ADDR_RESET  = 7'd72;
	localparam logic [7:0] ACK_LIMIT_RESET = 8'd250;

	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 8;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_DEV_ADDR  = 1'b0,
		CFG_ACK_LIMIT = 1'b1
	} cfg_idx_t;

	typedef enum logic [1:0] {
		KIND_SET_CTL   = 2'd0,
		KIND_READ_ADC  = 2'd1,
		KIND_WRITE_DAC = 2'd2,
		KIND_NONE      = 2'd3
	} kind_t;

	typedef enum logic [1:0] {
		OP_TICK = 2'd0,
		OP_REQ  = 2'd1,
		OP_NOP  = 2'd2
	} op_t;

	typedef struct packed {
		op_t        op;
		kind_t      kind;
		logic [7:0] ctl;
		logic [7:0] dac;
		logic       sda_in;
	} entry_t;

	typedef struct packed {
		logic [6:0] dev_addr;
		logic [7:0] ack_limit;
	} cfg_t;

endpackage
`default_nettype wire

[hdl/i2cad_if.sv]
// Stream interfaces for request items and result items.
// Depends on i2cad_pkg.
`default_nettype none
interface i2cad_req_if;
	import i2cad_pkg::*;
	logic       valid;
	logic       ready;
	logic       cmd;
	logic [1:0] kind;
	logic [7:0] control_byte;
	logic [7:0] dac_byte;
	logic       sda_in;
	modport source (output valid, cmd, kind, control_byte, dac_byte, sda_in, input ready);
	modport sink (input valid, cmd, kind, control_byte, dac_byte, sda_in, output ready);
endinterface

interface i2cad_res_if;
	import i2cad_pkg::*;
	logic       valid;
	logic       ready;
	logic       scl;
	logic       sda_out;
	logic       busy_res;
	logic       done_res;
	logic [7:0] read_data;
	logic       ack_missing;
	modport source (output valid, scl, sda_out, busy_res, done_res, read_data, ack_missing,
		input ready);
	modport sink (input valid, scl, sda_out, busy_res, done_res, read_data, ack_missing,
		output ready);
endinterface
`default_nettype wire

[hdl/i2cad_front.sv]
// Front end: accept request items and classify them into queue entries.
// Depends on i2cad_pkg and i2cad_if.
`default_nettype none
module i2cad_front (
	i2cad_req_if.sink           req,
	output i2cad_pkg::entry_t   push_entry,
	output logic                push,
	input  logic                queue_full
);
	import i2cad_pkg::*;

	op_t op;

	// Unknown request kinds collapse into a no-op here so the back end sees clean codes.
	always_comb begin
		if (!req.cmd) begin
			op = OP_TICK;
		end else if (kind_t'(req.kind) == KIND_NONE) begin
			op = OP_NOP;
		end else begin
			op = OP_REQ;
		end
	end

	assign req.ready         = !queue_full;
	assign push              = req.valid && !queue_full;
	assign push_entry.op     = op;
	assign push_entry.kind   = kind_t'(req.kind);
	assign push_entry.ctl    = req.control_byte;
	assign push_entry.dac    = req.dac_byte;
	assign push_entry.sda_in = req.sda_in;

endmodule
`default_nettype wire

[hdl/i2cad_queue.sv]
// Short entry queue between front end and sequencer.
// Depends on i2cad_pkg and the assertion macro header.
`default_nettype none
`include "i2c_master_adc_dac_transfer_defines.svh"
module i2cad_queue #(
	parameter int DEPTH = i2cad_pkg::QUEUE_DEPTH_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  i2cad_pkg::entry_t push_entry,
	output logic              full,
	output logic              pop_valid,
	input  logic              pop_ready,
	output i2cad_pkg::entry_t pop_entry
);
	import i2cad_pkg::*;

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);
	localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

	entry_t        mem_q [DEPTH];
	logic [AW-1:0] wr_ptr_q;
	logic [AW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;
	logic          pop;

	assign full      = (count_q == FULL_CNT);
	assign pop_valid = (count_q != '0);
	assign pop       = pop_valid && pop_ready;
	assign pop_entry = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == LAST) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	`I2CAD_ASSERT_IMPL(a_count_bound, clk, arst_n, 1'b1, count_q <= FULL_CNT, "queue overfilled")
	`I2CAD_ASSERT_IMPL(a_no_push_full, clk, arst_n, full, !push, "push into full queue")
	`I2CAD_ASSERT_NEXT(a_ptr_track, clk, arst_n, pop && !push && count_q == CW'(1), wr_ptr_q == rd_ptr_q, "pointers diverge on empty")

endmodule
`default_nettype wire

[hdl/i2cad_seq.sv]
// Back end: bus phase sequencer, at most one phase step per queued item,
// with its line levels and status held as the result register.
// Depends on i2cad_pkg, i2cad_if and the assertion macro header.
`default_nettype none
`include "i2c_master_adc_dac_transfer_defines.svh"
module i2cad_seq (
	input  logic              clk,
	input  logic              arst_n,
	input  i2cad_pkg::cfg_t   cfg,
	input  logic              q_valid,
	output logic              q_ready,
	input  i2cad_pkg::entry_t q_entry,
	i2cad_res_if.source       res
);
	import i2cad_pkg::*;

	typedef enum logic [3:0] {
		PH_IDLE     = 4'd0,
		PH_START_B  = 4'd1,
		PH_S_LOW    = 4'd2,
		PH_S_DATA   = 4'd3,
		PH_S_HIGH   = 4'd4,
		PH_S_FALL   = 4'd5,
		PH_W_REL    = 4'd6,
		PH_W_HIGH   = 4'd7,
		PH_W_POLL   = 4'd8,
		PH_R_LOW    = 4'd9,
		PH_R_HIGH   = 4'd10,
		PH_R_SAMPLE = 4'd11,
		PH_R_FALL   = 4'd12,
		PH_P_A      = 4'd13,
		PH_P_B      = 4'd14
	} phase_t;

	phase_t     phase_q, phase_d;
	logic [3:0] bit_cnt_q, bit_cnt_d, bit_inc;
	logic [7:0] shift_q, shift_d;
	logic [1:0] byte_idx_q, byte_idx_d;
	logic [7:0] wait_q, wait_d;
	kind_t      kind_q, kind_d;
	logic [7:0] ctl_q, ctl_d;
	logic [7:0] dac_q, dac_d;
	logic [7:0] result_q, result_d;
	logic       ack_q, ack_d;
	logic       scl_q, scl_d;
	logic       sda_q, sda_d;
	logic       done_q, done_d;
	logic       busy_q;
	logic       out_valid_q;
	logic       pop;

	function automatic logic [7:0] byte_for(input logic [1:0] idx, input kind_t k,
		input logic [6:0] addr, input logic [7:0] c, input logic [7:0] d);
		logic [7:0] wr;
		wr = {addr, 1'b0};
		if (idx == 2'd0) begin
			byte_for = (k == KIND_READ_ADC) ? (wr | 8'h01) : wr;
		end else if (idx == 2'd1) begin
			byte_for = c;
		end else begin
			byte_for = d;
		end
	endfunction

	assign q_ready = !out_valid_q || res.ready;
	assign pop     = q_valid && q_ready;
	assign bit_inc = bit_cnt_q + 4'd1;

	always_comb begin
		phase_d    = phase_q;
		bit_cnt_d  = bit_cnt_q;
		shift_d    = shift_q;
		byte_idx_d = byte_idx_q;
		wait_d     = wait_q;
		kind_d     = kind_q;
		ctl_d      = ctl_q;
		dac_d      = dac_q;
		result_d   = result_q;
		ack_d      = ack_q;
		scl_d      = scl_q;
		sda_d      = sda_q;
		done_d     = 1'b0;
		case (q_entry.op)
			OP_REQ: begin
				if (phase_q == PH_IDLE) begin
					kind_d  = q_entry.kind;
					ctl_d   = q_entry.ctl;
					dac_d   = q_entry.dac;
					ack_d   = 1'b0;
					sda_d   = 1'b1;
					scl_d   = 1'b1;
					phase_d = PH_START_B;
				end
			end
			OP_TICK: begin
				unique case (phase_q)
					PH_IDLE: begin
					end
					PH_START_B: begin
						sda_d      = 1'b0;
						byte_idx_d = 2'd0;
						shift_d    = byte_for(2'd0, kind_q, cfg.dev_addr, ctl_q, dac_q);
						phase_d    = PH_S_LOW;
					end
					PH_S_LOW: begin
						scl_d     = 1'b0;
						bit_cnt_d = 4'd0;
						phase_d   = PH_S_DATA;
					end
					PH_S_DATA: begin
						sda_d   = shift_q[7];
						shift_d = {shift_q[6:0], 1'b0};
						phase_d = PH_S_HIGH;
					end
					PH_S_HIGH: begin
						scl_d   = 1'b1;
						phase_d = PH_S_FALL;
					end
					PH_S_FALL: begin
						scl_d     = 1'b0;
						bit_cnt_d = bit_inc;
						phase_d   = (bit_inc >= 4'd8) ? PH_W_REL : PH_S_DATA;
					end
					PH_W_REL: begin
						sda_d   = 1'b1;
						phase_d = PH_W_HIGH;
					end
					PH_W_HIGH: begin
						scl_d   = 1'b1;
						wait_d  = cfg.ack_limit;
						phase_d = PH_W_POLL;
					end
					PH_W_POLL: begin
						if (q_entry.sda_in && wait_q != 8'd0) begin
							wait_d = wait_q - 8'd1;
						end else begin
							if (q_entry.sda_in) begin
								ack_d = 1'b1;
							end
							scl_d = 1'b0;
							if (kind_q == KIND_READ_ADC) begin
								phase_d = PH_R_LOW;
							end else if ((kind_q == KIND_SET_CTL && byte_idx_q >= 2'd1) ||
								byte_idx_q >= 2'd2) begin
								phase_d = PH_P_A;
							end else begin
								byte_idx_d = byte_idx_q + 2'd1;
								shift_d    = byte_for(byte_idx_q + 2'd1, kind_q, cfg.dev_addr,
									ctl_q, dac_q);
								phase_d    = PH_S_LOW;
							end
						end
					end
					PH_R_LOW: begin
						scl_d     = 1'b0;
						bit_cnt_d = 4'd0;
						phase_d   = PH_R_HIGH;
					end
					PH_R_HIGH: begin
						sda_d   = 1'b1;
						scl_d   = 1'b1;
						phase_d = PH_R_SAMPLE;
					end
					PH_R_SAMPLE: begin
						shift_d = {shift_q[6:0], q_entry.sda_in};
						phase_d = PH_R_FALL;
					end
					PH_R_FALL: begin
						scl_d     = 1'b0;
						bit_cnt_d = bit_inc;
						if (bit_inc >= 4'd8) begin
							result_d = shift_q;
							phase_d  = PH_P_A;
						end else begin
							phase_d = PH_R_HIGH;
						end
					end
					PH_P_A: begin
						sda_d   = 1'b0;
						scl_d   = 1'b1;
						phase_d = PH_P_B;
					end
					PH_P_B: begin
						sda_d   = 1'b1;
						done_d  = 1'b1;
						phase_d = PH_IDLE;
					end
					default: begin
						phase_d = PH_IDLE;
					end
				endcase
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_IDLE;
			bit_cnt_q   <= '0;
			shift_q     <= '0;
			byte_idx_q  <= '0;
			wait_q      <= '0;
			kind_q      <= KIND_SET_CTL;
			ctl_q       <= '0;
			dac_q       <= '0;
			result_q    <= '0;
			ack_q       <= 1'b0;
			scl_q       <= 1'b1;
			sda_q       <= 1'b1;
			done_q      <= 1'b0;
			busy_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				phase_q     <= phase_d;
				bit_cnt_q   <= bit_cnt_d;
				shift_q     <= shift_d;
				byte_idx_q  <= byte_idx_d;
				wait_q      <= wait_d;
				kind_q      <= kind_d;
				ctl_q       <= ctl_d;
				dac_q       <= dac_d;
				result_q    <= result_d;
				ack_q       <= ack_d;
				scl_q       <= scl_d;
				sda_q       <= sda_d;
				done_q      <= done_d;
				busy_q      <= (phase_d != PH_IDLE);
				out_valid_q <= 1'b1;
			end else if (res.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign res.valid       = out_valid_q;
	assign res.scl         = scl_q;
	assign res.sda_out     = sda_q;
	assign res.busy_res    = busy_q;
	assign res.done_res    = done_q;
	assign res.read_data   = result_q;
	assign res.ack_missing = ack_q;

	`I2CAD_ASSERT_IMPL(a_idle_lines_high, clk, arst_n, phase_q == PH_IDLE, scl_q && sda_q, "bus not released while idle")
	`I2CAD_ASSERT_IMPL(a_done_ends, clk, arst_n, done_q, !busy_q && phase_q == PH_IDLE, "done while still busy")
	`I2CAD_ASSERT_NEXT(a_req_clears_ack, clk, arst_n, pop && q_entry.op == OP_REQ && phase_q == PH_IDLE, !ack_q && busy_q, "request did not start cleanly")

endmodule
`default_nettype wire

[hdl/i2c_master_adc_dac_transfer.sv]
// Top level of the bus master: configuration registers, front end, queue, sequencer.
// Depends on i2cad_pkg, i2cad_if, i2cad_front, i2cad_queue, i2cad_seq.
//
// Channel   Dir  Handshake    Payload
// req       in   valid/ready  cmd, kind, control_byte, dac_byte, sda_in
// res       out  valid/ready  scl, sda_out, busy_res, done_res, read_data, ack_missing
// cfg       in   cfg_we       cfg_index, cfg_wdata (no read-back)
//
// One item per cycle sustained while res is ready; each item moves the bus sequencer
// by at most one phase and yields one result item, registered by the queue write
// and then by the sequencer step, a single phase update that sets the per-item cost.
// Reset clears all control state and returns both lines to released; no clearing pass.
// When res stalls, the result register holds, then up to QUEUE_DEPTH items pile up in
// the queue before req.ready drops.
`default_nettype none
module i2c_master_adc_dac_transfer #(
	parameter int QUEUE_DEPTH = i2cad_pkg::QUEUE_DEPTH_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	i2cad_req_if.sink                            req,
	i2cad_res_if.source                          res,
	input  logic                                 cfg_we,
	input  logic [i2cad_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [i2cad_pkg::CFG_DATA_W-1:0]     cfg_wdata
);
	import i2cad_pkg::*;

	cfg_t   cfg_q;
	entry_t push_entry;
	entry_t pop_entry;
	logic   push;
	logic   queue_full;
	logic   q_valid;
	logic   q_ready;

	// Configuration registers; the user must write them only while the bus is idle,
	// which the block itself does not enforce, so the sequencer reads them directly.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.dev_addr  <= DEV_ADDR_RESET;
			cfg_q.ack_limit <= ACK_LIMIT_RESET;
		end else if (cfg_we) begin
			unique case (cfg_idx_t'(cfg_index))
				CFG_DEV_ADDR:  cfg_q.dev_addr  <= cfg_wdata[6:0];
				CFG_ACK_LIMIT: cfg_q.ack_limit <= cfg_wdata[7:0];
				default: begin
				end
			endcase
		end
	end

	// Front end: classify ticks, requests and ignored request kinds.
	i2cad_front u_front (
		.req        (req),
		.push_entry (push_entry),
		.push       (push),
		.queue_full (queue_full)
	);

	// Decouple the accepting side from the sequencer and its result register.
	i2cad_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.full       (queue_full),
		.pop_valid  (q_valid),
		.pop_ready  (q_ready),
		.pop_entry  (pop_entry)
	);

	// Back end: step the bus phases and hold the result item.
	i2cad_seq u_seq (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg_q),
		.q_valid (q_valid),
		.q_ready (q_ready),
		.q_entry (pop_entry),
		.res     (res)
	);

endmodule
`default_nettype wire

[bench/i2c_master_adc_dac_transfer_tb.sv]
// Self-checking bench for the I2C ADC/DAC bus master: drives request items, predicts every
// result item in step with the sequencer, and compares the line levels and flags field by field.
// Depends on i2cad_pkg, i2cad_if and the i2c_master_adc_dac_transfer RTL.
`timescale 1ns / 100ps
module i2c_master_adc_dac_transfer_tb;
	import i2cad_pkg::*;

	localparam logic CMD_TICK    = 1'b0;
	localparam logic CMD_REQ     = 1'b1;
	localparam int   CYCLE_LIMIT = 300000;
	localparam int   DRAIN_WAIT  = 6;

	// Sequencer phases as the bench tracks them.
	typedef enum logic [4:0] {
		BUS_IDLE, BUS_START, BUS_TX_LOW, BUS_TX_DATA, BUS_TX_HIGH, BUS_TX_FALL,
		BUS_ACK_REL, BUS_ACK_HIGH, BUS_ACK_POLL, BUS_RX_LOW, BUS_RX_HIGH,
		BUS_RX_SAMPLE, BUS_RX_FALL, BUS_STOP_A, BUS_STOP_B
	} bus_phase_t;

	typedef struct packed {
		logic       cmd;
		kind_t      kind;
		logic [7:0] ctl;
		logic [7:0] dac;
		logic       sda;
	} req_item_t;

	typedef struct packed {
		logic       scl;
		logic       sda;
		logic       busy;
		logic       done;
		logic [7:0] rdata;
		logic       ackm;
	} bus_lines_t;

	logic clk = 1'b0;
	logic arst_n;
	logic cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0] cfg_wdata;

	i2cad_req_if req();
	i2cad_res_if res();

	i2c_master_adc_dac_transfer uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.res       (res),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Shadow of the bus sequencer, advanced once per accepted item.
	bus_phase_t bus_phase;
	logic [3:0] bits_done;
	logic [7:0] shifter;
	logic [1:0] byte_sel;
	logic [7:0] poll_left;
	kind_t      txn_kind;
	logic [7:0] txn_ctl;
	logic [7:0] txn_dac;
	logic [7:0] adc_byte;
	logic       nack_seen;
	logic       scl_lvl;
	logic       sda_lvl;
	logic [6:0] cfg_addr;
	logic [7:0] cfg_ack_limit;

	bus_lines_t line_expect[$];
	bus_lines_t want;

	int send_idle_pct;
	int recv_stall_pct;
	int items_sent;
	int bus_items;
	int results_seen;
	int mismatches;
	int txn_count;
	int ack_timeouts;

	// Byte sent in slot sel of the current transaction: address, control, DAC value.
	function automatic logic [7:0] tx_byte(input logic [1:0] sel);
		case (sel)
			2'd0: tx_byte = {cfg_addr, txn_kind == KIND_READ_ADC};
			2'd1: tx_byte = txn_ctl;
			default: tx_byte = txn_dac;
		endcase
	endfunction

	// Advance the shadow sequencer by one item and return the line levels it leaves.
	function automatic bus_lines_t predict_lines(input req_item_t it);
		bus_lines_t r;
		logic finished;
		finished = 1'b0;
		if (it.cmd == CMD_REQ) begin
			// a request only starts from idle; busy or kind-none requests fall through
			if (bus_phase == BUS_IDLE && it.kind != KIND_NONE) begin
				txn_kind  = it.kind;
				txn_ctl   = it.ctl;
				txn_dac   = it.dac;
				nack_seen = 1'b0;
				sda_lvl   = 1'b1;
				scl_lvl   = 1'b1;
				bus_phase = BUS_START;
			end
		end else begin
			case (bus_phase)
				BUS_IDLE: ;
				BUS_START: begin
					sda_lvl   = 1'b0;
					byte_sel  = 2'd0;
					shifter   = tx_byte(2'd0);
					bus_phase = BUS_TX_LOW;
				end
				BUS_TX_LOW: begin
					scl_lvl   = 1'b0;
					bits_done = 4'd0;
					bus_phase = BUS_TX_DATA;
				end
				BUS_TX_DATA: begin
					sda_lvl   = shifter[7];
					shifter   = {shifter[6:0], 1'b0};
					bus_phase = BUS_TX_HIGH;
				end
				BUS_TX_HIGH: begin
					scl_lvl   = 1'b1;
					bus_phase = BUS_TX_FALL;
				end
				BUS_TX_FALL: begin
					scl_lvl   = 1'b0;
					bits_done = bits_done + 4'd1;
					bus_phase = (bits_done >= 4'd8) ? BUS_ACK_REL : BUS_TX_DATA;
				end
				BUS_ACK_REL: begin
					sda_lvl   = 1'b1;
					bus_phase = BUS_ACK_HIGH;
				end
				BUS_ACK_HIGH: begin
					scl_lvl   = 1'b1;
					poll_left = cfg_ack_limit;
					bus_phase = BUS_ACK_POLL;
				end
				BUS_ACK_POLL: begin
					if (it.sda && poll_left != 8'd0) begin
						poll_left = poll_left - 8'd1;
					end else begin
						if (it.sda) begin
							nack_seen = 1'b1;
							ack_timeouts++;
						end
						scl_lvl = 1'b0;
						if (txn_kind == KIND_READ_ADC) begin
							bus_phase = BUS_RX_LOW;
						end else if ((txn_kind == KIND_SET_CTL && byte_sel >= 2'd1) ||
								byte_sel >= 2'd2) begin
							bus_phase = BUS_STOP_A;
						end else begin
							byte_sel  = byte_sel + 2'd1;
							shifter   = tx_byte(byte_sel);
							bus_phase = BUS_TX_LOW;
						end
					end
				end
				BUS_RX_LOW: begin
					scl_lvl   = 1'b0;
					bits_done = 4'd0;
					bus_phase = BUS_RX_HIGH;
				end
				BUS_RX_HIGH: begin
					sda_lvl   = 1'b1;
					scl_lvl   = 1'b1;
					bus_phase = BUS_RX_SAMPLE;
				end
				BUS_RX_SAMPLE: begin
					shifter   = {shifter[6:0], it.sda};
					bus_phase = BUS_RX_FALL;
				end
				BUS_RX_FALL: begin
					scl_lvl   = 1'b0;
					bits_done = bits_done + 4'd1;
					if (bits_done >= 4'd8) begin
						adc_byte  = shifter;
						bus_phase = BUS_STOP_A;
					end else begin
						bus_phase = BUS_RX_HIGH;
					end
				end
				BUS_STOP_A: begin
					sda_lvl   = 1'b0;
					scl_lvl   = 1'b1;
					bus_phase = BUS_STOP_B;
				end
				BUS_STOP_B: begin
					sda_lvl   = 1'b1;
					finished  = 1'b1;
					bus_phase = BUS_IDLE;
					txn_count++;
				end
				default: bus_phase = BUS_IDLE;
			endcase
		end
		r.scl   = scl_lvl;
		r.sda   = sda_lvl;
		r.busy  = (bus_phase != BUS_IDLE);
		r.done  = finished;
		r.rdata = adc_byte;
		r.ackm  = nack_seen;
		return r;
	endfunction

	function automatic req_item_t random_item(input logic cmd);
		req_item_t it;
		it.cmd  = cmd;
		it.kind = kind_t'($urandom_range(3));
		it.ctl  = 8'($urandom_range(255));
		it.dac  = 8'($urandom_range(255));
		it.sda  = 1'($urandom_range(1));
		return it;
	endfunction

	// Send one item: idle the sender at random, hold valid until ready, then predict.
	task automatic send_item(input req_item_t it);
		while ($urandom_range(99) < send_idle_pct) begin
			req.valid <= 1'b0;
			@(posedge clk);
		end
		req.valid        <= 1'b1;
		req.cmd          <= it.cmd;
		req.kind         <= it.kind;
		req.control_byte <= it.ctl;
		req.dac_byte     <= it.dac;
		req.sda_in       <= it.sda;
		do
			@(posedge clk);
		while (!req.ready);
		// only items that move the sequencer count toward the stimulus budget
		if ((it.cmd == CMD_TICK && bus_phase != BUS_IDLE) ||
				(it.cmd == CMD_REQ && bus_phase == BUS_IDLE && it.kind != KIND_NONE))
			bus_items++;
		line_expect.push_back(predict_lines(it));
		items_sent++;
	endtask

	// Start one transaction and tick it to its stop condition. high_pct sets how often the
	// slave leaves SDA high while acks are polled; busy_pct sprinkles in ignored requests.
	task automatic run_transaction(input kind_t kind, input logic [7:0] ctl, dac,
			input int high_pct, busy_pct);
		req_item_t it;
		it      = random_item(CMD_REQ);
		it.kind = kind;
		it.ctl  = ctl;
		it.dac  = dac;
		send_item(it);
		while (bus_phase != BUS_IDLE) begin
			if ($urandom_range(99) < busy_pct) begin
				it = random_item(CMD_REQ);
			end else begin
				it = random_item(CMD_TICK);
				// read bits are random data; elsewhere the bias drives the ack polls
				if (bus_phase != BUS_RX_SAMPLE)
					it.sda = ($urandom_range(99) < high_pct);
			end
			send_item(it);
		end
	endtask

	// Drop valid, wait until every predicted result is back, then let the pipeline settle.
	task automatic drain_results();
		req.valid <= 1'b0;
		while (line_expect.size() != 0)
			@(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);
	endtask

	// Write both registers on back-to-back edges; call only with the sequencer idle.
	task automatic set_config(input logic [6:0] addr, input logic [7:0] limit);
		cfg_we    <= 1'b1;
		cfg_index <= CFG_DEV_ADDR;
		cfg_wdata <= {1'b0, addr};
		@(posedge clk);
		cfg_index <= CFG_ACK_LIMIT;
		cfg_wdata <= limit;
		@(posedge clk);
		cfg_we        <= 1'b0;
		cfg_addr      = addr;
		cfg_ack_limit = limit;
	endtask

	// Ticks while idle and kind-none requests must leave everything as it is.
	task automatic test_idle_items();
		req_item_t it;
		it      = random_item(CMD_TICK);
		it.sda  = 1'b0;
		send_item(it);
		it.sda  = 1'b1;
		send_item(it);
		it      = '{cmd: CMD_REQ, kind: KIND_NONE, ctl: 8'hFF, dac: 8'hFF, sda: 1'b1};
		send_item(it);
		it      = '{cmd: CMD_REQ, kind: KIND_NONE, ctl: 8'h00, dac: 8'h00, sda: 1'b0};
		send_item(it);
	endtask

	// Each transaction kind at reset settings, the DAC write twice, with data bytes at their extremes.
	task automatic test_each_kind();
		run_transaction(KIND_SET_CTL, 8'hFF, 8'h00, 0, 0);
		run_transaction(KIND_READ_ADC, 8'h00, 8'hFF, 0, 4);
		run_transaction(KIND_WRITE_DAC, 8'h00, 8'hFF, 0, 4);
		run_transaction(KIND_WRITE_DAC, 8'hFF, 8'h00, 50, 0);
	endtask

	// Zero ack limit: the first poll decides, so a high SDA times out at once.
	task automatic test_ack_limit_zero();
		drain_results();
		set_config(7'd0, 8'd0);
		run_transaction(KIND_SET_CTL, 8'hA5, 8'h5A, 100, 0);
		run_transaction(KIND_READ_ADC, 8'h00, 8'h00, 100, 0);
		run_transaction(KIND_WRITE_DAC, 8'h3C, 8'hC3, 0, 0);
	endtask

	// Widest address and longest ack wait, run out in full once.
	task automatic test_max_ack_wait();
		drain_results();
		set_config(7'd127, 8'd255);
		run_transaction(KIND_READ_ADC, 8'h00, 8'h00, 100, 0);
		run_transaction(KIND_SET_CTL, 8'h81, 8'h7E, 30, 0);
	endtask

	// Mostly well-formed transactions with random content, some idle noise in between.
	task automatic test_random_phase(input int idle_pct, stall_pct,
			input logic [7:0] limit_cap, input int quota);
		int first;
		int high_pct;
		req_item_t it;
		drain_results();
		set_config(7'($urandom_range(127)), 8'($urandom_range(limit_cap)));
		send_idle_pct  = idle_pct;
		recv_stall_pct = stall_pct;
		first = bus_items;
		while (bus_items - first < quota) begin
			if ($urandom_range(99) < 8) begin
				it = random_item(1'($urandom_range(1)));
				if (it.cmd == CMD_REQ)
					it.kind = KIND_NONE;
				send_item(it);
			end else begin
				case ($urandom_range(3))
					0: high_pct = 0;
					1: high_pct = 30;
					2: high_pct = 70;
					default: high_pct = (cfg_ack_limit <= 8'd16) ? 100 : 90;
				endcase
				run_transaction(kind_t'($urandom_range(2)), 8'($urandom_range(255)),
					8'($urandom_range(255)), high_pct, 6);
			end
		end
	endtask

	// Receiver: stall at random according to the current phase setting.
	initial begin
		res.ready <= 1'b0;
		forever begin
			@(posedge clk);
			res.ready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	task automatic check_field(input string name, input logic [7:0] exp_v, got_v);
		if (exp_v !== got_v) begin
			mismatches++;
			if (mismatches <= 10)
				$display("result %0d: %s expected %h, got %h", results_seen, name, exp_v, got_v);
		end
	endtask

	// Compare each accepted result with the oldest prediction.
	always @(posedge clk) begin
		if (arst_n && res.valid && res.ready) begin
			if (line_expect.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("result %0d arrived with nothing predicted", results_seen);
			end else begin
				want = line_expect.pop_front();
				check_field("scl", 8'(want.scl), 8'(res.scl));
				check_field("sda_out", 8'(want.sda), 8'(res.sda_out));
				check_field("busy_res", 8'(want.busy), 8'(res.busy_res));
				check_field("done_res", 8'(want.done), 8'(res.done_res));
				check_field("read_data", want.rdata, res.read_data);
				check_field("ack_missing", 8'(want.ackm), 8'(res.ack_missing));
			end
			results_seen++;
		end
	end

	// Watchdog: end the run if it hangs.
	initial begin : watchdog
		int cycles;
		for (cycles = 0; cycles < CYCLE_LIMIT; cycles++)
			@(posedge clk);
		$display("timeout after %0d cycles, %0d results pending", cycles, line_expect.size());
		$display("end of test: mismatches");
		$finish;
	end

	initial begin
		arst_n           <= 1'b0;
		req.valid        <= 1'b0;
		req.cmd          <= CMD_TICK;
		req.kind         <= KIND_SET_CTL;
		req.control_byte <= 8'h00;
		req.dac_byte     <= 8'h00;
		req.sda_in       <= 1'b1;
		cfg_we           <= 1'b0;
		cfg_index        <= CFG_DEV_ADDR;
		cfg_wdata        <= '0;

		// reset state of the shadow sequencer
		bus_phase     = BUS_IDLE;
		bits_done     = 4'd0;
		shifter       = 8'd0;
		byte_sel      = 2'd0;
		poll_left     = 8'd0;
		txn_kind      = KIND_SET_CTL;
		txn_ctl       = 8'd0;
		txn_dac       = 8'd0;
		adc_byte      = 8'd0;
		nack_seen     = 1'b0;
		scl_lvl       = 1'b1;
		sda_lvl       = 1'b1;
		cfg_addr      = DEV_ADDR_RESET;
		cfg_ack_limit = ACK_LIMIT_RESET;

		send_idle_pct  = 0;
		recv_stall_pct = 0;
		items_sent     = 0;
		bus_items      = 0;
		results_seen   = 0;
		mismatches     = 0;
		txn_count      = 0;
		ack_timeouts   = 0;

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		test_idle_items();
		test_each_kind();
		test_ack_limit_zero();
		test_max_ack_wait();
		test_random_phase(0, 0, 8'd3, 40);
		test_random_phase(59, 0, 8'd255, 40);
		test_random_phase(0, 59, 8'd20, 40);
		test_random_phase(35, 35, 8'd255, 40);
		drain_results();

		$display("sent %0d items (%0d moved the bus), checked %0d results", items_sent,
			bus_items, results_seen);
		$display("covered %0d transactions with %0d ack timeouts", txn_count, ack_timeouts);
		if (mismatches == 0) begin
			$display("end of test: clean");
		end else begin
			$display("%0d mismatches in total", mismatches);
			$display("end of test: mismatches");
		end
		$finish;
	end

endmodule
